>>> src/vertex_layout_string_parser_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the vertex layout string parser.
// Both macros sample on clk_i and are disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef VERTEX_LAYOUT_STRING_PARSER_ASSERT_SVH
`define VERTEX_LAYOUT_STRING_PARSER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VLSP_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define VLSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/vlsp_pkg.sv
`default_nettype none
// ============================================================================
// vlsp_pkg
// Types, character codes and name tables shared by the layout string parser.
// ============================================================================
package vlsp_pkg;

  localparam int unsigned MaxLocationsDefault = 32;
  localparam int unsigned RecFifoDepth        = 4;

  localparam logic RecKindAttr    = 1'b0;
  localparam logic RecKindVerdict = 1'b1;

  localparam logic [3:0] TypeFloat  = 4'd0;
  localparam logic [3:0] TypeHalf   = 4'd1;
  localparam logic [3:0] TypeInt    = 4'd2;
  localparam logic [3:0] TypeUint   = 4'd3;
  localparam logic [3:0] TypeShort  = 4'd4;
  localparam logic [3:0] TypeUshort = 4'd5;
  localparam logic [3:0] TypeByte   = 4'd6;
  localparam logic [3:0] TypeUbyte  = 4'd7;
  localparam logic [3:0] TypeUnorm  = 4'd8;
  localparam logic [3:0] TypeSnorm  = 4'd9;

  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChDigit0 = 8'h30;
  localparam logic [7:0] ChDigit2 = 8'h32;
  localparam logic [7:0] ChDigit3 = 8'h33;
  localparam logic [7:0] ChDigit4 = 8'h34;
  localparam logic [7:0] ChDigit9 = 8'h39;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChLowerI = 8'h69;

  typedef struct packed {
    logic       record_kind;
    logic [3:0] base_type;
    logic [2:0] components;
    logic [4:0] location;
    logic [8:0] byte_offset;
    logic       instanced;
    logic       layout_ok;
    logic [9:0] stride;
    logic [5:0] attribute_count;
  } rec_t;

  function automatic logic [7:0] type_name_char(logic [3:0] k, logic [2:0] pos);
    logic [47:0] s;
    logic [5:0]  sh;
    unique case (k)
      TypeFloat:  s = "float ";
      TypeHalf:   s = "half  ";
      TypeInt:    s = "int   ";
      TypeUint:   s = "uint  ";
      TypeShort:  s = "short ";
      TypeUshort: s = "ushort";
      TypeByte:   s = "byte  ";
      TypeUbyte:  s = "ubyte ";
      TypeUnorm:  s = "unorm ";
      TypeSnorm:  s = "snorm ";
      default:    s = '0;
    endcase
    if (pos > 3'd5) begin
      return ChNul;
    end
    sh = {3'(3'd5 - pos), 3'b000};
    return s[sh +: 8];
  endfunction

  function automatic logic [2:0] type_name_len(logic [3:0] k);
    logic [2:0] n;
    unique case (k)
      TypeFloat, TypeShort, TypeUbyte, TypeUnorm, TypeSnorm: n = 3'd5;
      TypeHalf, TypeUint, TypeByte:                          n = 3'd4;
      TypeInt:                                               n = 3'd3;
      TypeUshort:                                            n = 3'd6;
      default:                                               n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic [2:0] type_elem_bytes(logic [3:0] k);
    logic [2:0] n;
    unique case (k)
      TypeFloat, TypeInt, TypeUint:  n = 3'd4;
      TypeHalf, TypeShort, TypeUshort: n = 3'd2;
      default:                       n = 3'd1;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] attr_char(logic [1:0] pos);
    logic [7:0] c;
    unique case (pos)
      2'd0:    c = 8'h41;
      2'd1:    c = 8'h54;
      2'd2:    c = 8'h54;
      default: c = 8'h52;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

>>> src/vlsp_char_if.sv
`default_nettype none
// ============================================================================
// vlsp_char_if
// Character channel: one byte of the layout string and its last-byte flag.
// ============================================================================
interface vlsp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       final_char;

  modport source (output valid, output character, output final_char, input ready);
  modport sink (input valid, input character, input final_char, output ready);
endinterface
`default_nettype wire

>>> src/vlsp_rec_if.sv
`default_nettype none
// ============================================================================
// vlsp_rec_if
// Record channel: attribute records and the closing verdict record.
// ============================================================================
interface vlsp_rec_if;
  logic       valid;
  logic       ready;
  logic       record_kind;
  logic [3:0] base_type;
  logic [2:0] components;
  logic [4:0] location;
  logic [8:0] byte_offset;
  logic       instanced;
  logic       layout_ok;
  logic [9:0] stride;
  logic [5:0] attribute_count;

  modport source (
    output valid, output record_kind, output base_type, output components,
    output location, output byte_offset, output instanced, output layout_ok,
    output stride, output attribute_count, input ready
  );
  modport sink (
    input valid, input record_kind, input base_type, input components,
    input location, input byte_offset, input instanced, input layout_ok,
    input stride, input attribute_count, output ready
  );
endinterface
`default_nettype wire

>>> src/vertex_layout_string_parser.sv
`default_nettype none
// ============================================================================
// vertex_layout_string_parser
// Parses a vertex layout string, one byte per request, into attribute records
// and a closing verdict record carrying the stride and attribute count.
//
// char_i takes one byte per request; final_char marks the last byte. rec_o
// gives attribute records (record_kind 0) and, after the last byte, one
// verdict record (record_kind 1). Attribute records are only meaningful when
// the verdict reports layout_ok.
// A request is registered on acceptance; its records are registered in the
// queue before they can be taken. The parser takes one byte per cycle while
// the queue has room; a byte that yields both an attribute and the verdict
// pushes both records together. A four-entry record queue parts the two sides:
// a byte is parsed only while the queue has room for two records, so a stalled
// receiver holds the queue and, once it fills, char_i.ready drops.
// Reset clears the parser to the start of a string and empties the queue.
// ============================================================================
module vertex_layout_string_parser import vlsp_pkg::*; #(
  parameter int unsigned MAX_LOCATIONS = MaxLocationsDefault
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  vlsp_char_if.sink   char_i,
  vlsp_rec_if.source  rec_o
);

  logic       in_valid_q;
  logic [7:0] char_q;
  logic       fin_q;
  logic       room;
  logic       step;
  logic       accept;
  rec_t       attr_rec, verdict_rec, head_rec;
  logic       attr_valid, verdict_valid;
  logic       push_a, push_b;
  rec_t       data_a;

  assign step         = in_valid_q && room;
  assign char_i.ready = !in_valid_q || step;
  assign accept       = char_i.valid && char_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      char_q <= char_i.character;
      fin_q  <= char_i.final_char;
    end
  end

  vlsp_parse_core #(
    .MAX_LOCATIONS(MAX_LOCATIONS)
  ) u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .character_i    (char_q),
    .final_char_i   (fin_q),
    .attr_o         (attr_rec),
    .attr_valid_o   (attr_valid),
    .verdict_o      (verdict_rec),
    .verdict_valid_o(verdict_valid)
  );

  assign push_a = step && (attr_valid || verdict_valid);
  assign push_b = step && attr_valid && verdict_valid;
  assign data_a = attr_valid ? attr_rec : verdict_rec;

  vlsp_rec_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_a_i(push_a),
    .data_a_i(data_a),
    .push_b_i(push_b),
    .data_b_i(verdict_rec),
    .room_o  (room),
    .valid_o (rec_o.valid),
    .ready_i (rec_o.ready),
    .data_o  (head_rec)
  );

  assign rec_o.record_kind     = head_rec.record_kind;
  assign rec_o.base_type       = head_rec.base_type;
  assign rec_o.components      = head_rec.components;
  assign rec_o.location        = head_rec.location;
  assign rec_o.byte_offset     = head_rec.byte_offset;
  assign rec_o.instanced       = head_rec.instanced;
  assign rec_o.layout_ok       = head_rec.layout_ok;
  assign rec_o.stride          = head_rec.stride;
  assign rec_o.attribute_count = head_rec.attribute_count;

endmodule
`default_nettype wire

>>> src/vlsp_parse_core.sv
`default_nettype none
// ============================================================================
// vlsp_parse_core
// Parser state and the combinational step that consumes one character.
// ============================================================================
module vlsp_parse_core import vlsp_pkg::*; #(
  parameter int unsigned MAX_LOCATIONS = MaxLocationsDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       step_i,
  input  wire logic [7:0] character_i,
  input  wire logic       final_char_i,
  output rec_t            attr_o,
  output logic            attr_valid_o,
  output rec_t            verdict_o,
  output logic            verdict_valid_o
);

  typedef enum logic [2:0] {
    PhGap, PhName, PhSuffix, PhPeek, PhDigits, PhHalt
  } phase_e;

  localparam logic [1:0] SfxNone  = 2'd0;
  localparam logic [1:0] SfxColon = 2'd1;
  localparam logic [1:0] SfxInst  = 2'd3;

  typedef struct packed {
    phase_e     phase;
    logic [2:0] mpos;
    logic [9:0] cand;
    logic [2:0] cnt;
    logic [1:0] sfx;
    logic [3:0] ptype;
    logic [2:0] pcomp;
    logic       pinst;
    logic [6:0] loc_acc;
    logic [6:0] next_loc;
    logic [9:0] off;
    logic       failed;
    logic [5:0] total;
  } pst_t;

  typedef struct packed {
    pst_t                     s;
    logic [MAX_LOCATIONS-1:0] used;
    logic                     av;
    rec_t                     arec;
  } ctx_t;

  localparam pst_t PstReset = '{
    phase: PhGap, mpos: '0, cand: '1, cnt: 3'd1, sfx: SfxNone, ptype: '0,
    pcomp: 3'd1, pinst: 1'b0, loc_acc: '0, next_loc: '0, off: '0,
    failed: 1'b0, total: '0
  };

  function automatic ctx_t set_fail(ctx_t c);
    c.s.failed = 1'b1;
    c.s.phase  = PhHalt;
    return c;
  endfunction

  function automatic logic [4:0] complete_name(pst_t s);
    logic [4:0] r;
    r = '0;
    for (int k = 9; k >= 0; k--) begin
      if (s.cand[k] && type_name_len(4'(k)) == s.mpos) begin
        r = {1'b1, 4'(k)};
      end
    end
    return r;
  endfunction

  function automatic ctx_t commit(ctx_t c, logic [6:0] loc, logic expl);
    logic [4:0]               size;
    logic [10:0]              sum;
    logic [MAX_LOCATIONS-1:0] sh;
    size = 5'(type_elem_bytes(c.s.ptype)) * 5'(c.s.pcomp);
    sum  = 11'(c.s.off) + 11'(size);
    sh   = c.used >> loc;
    if (loc >= 7'(MAX_LOCATIONS) || sh[0]) begin
      c = set_fail(c);
    end else if (c.s.off > 10'd511 || sum > 11'd1023 || c.s.total >= 6'd63) begin
      c = set_fail(c);
    end else begin
      c.av   = 1'b1;
      c.arec = '{
        record_kind: RecKindAttr, base_type: c.s.ptype, components: c.s.pcomp,
        location: loc[4:0], byte_offset: c.s.off[8:0], instanced: c.s.pinst,
        layout_ok: 1'b0, stride: '0, attribute_count: '0
      };
      c.used       = c.used | (MAX_LOCATIONS'(1) << loc);
      c.s.off      = 10'(sum);
      c.s.total    = c.s.total + 6'd1;
      c.s.next_loc = expl ? loc + 7'd1 : c.s.next_loc + 7'd1;
    end
    return c;
  endfunction

  function automatic ctx_t name_feed(ctx_t c, logic [7:0] ch);
    logic [4:0] cn;
    logic [9:0] nc;
    logic       tail;
    cn   = complete_name(c.s);
    tail = ch == ChDigit2 || ch == ChDigit3 || ch == ChDigit4 || ch == ChColon;
    nc   = '0;
    if (cn[4] && tail) begin
      c.s.ptype = cn[3:0];
      c.s.cnt   = (ch == ChColon) ? 3'd1 : ch[2:0];
      c.s.sfx   = (ch == ChColon) ? SfxColon : SfxNone;
      c.s.phase = PhSuffix;
    end else begin
      for (int i = 0; i < 10; i++) begin
        if (c.s.cand[i] && type_name_len(4'(i)) > c.s.mpos &&
            type_name_char(4'(i), c.s.mpos) == ch) begin
          nc[i] = 1'b1;
        end
      end
      if (nc == '0) begin
        c = set_fail(c);
      end else begin
        c.s.cand = nc;
        c.s.mpos = c.s.mpos + 3'd1;
      end
    end
    return c;
  endfunction

  function automatic ctx_t suffix_feed(ctx_t c, logic [7:0] ch);
    if (c.s.sfx == SfxNone && ch == ChColon) begin
      c.s.sfx = SfxColon;
    end else if (c.s.sfx == SfxColon && ch == ChLowerI) begin
      c.s.sfx = SfxInst;
    end else begin
      c = set_fail(c);
    end
    return c;
  endfunction

  function automatic ctx_t start_name(ctx_t c, logic [7:0] ch);
    c.s.phase = PhName;
    c.s.mpos  = '0;
    c.s.cand  = '1;
    c.s.cnt   = 3'd1;
    c.s.sfx   = SfxNone;
    return name_feed(c, ch);
  endfunction

  function automatic ctx_t finish_type(ctx_t c);
    logic [4:0] cn;
    logic       go;
    cn = complete_name(c.s);
    go = 1'b1;
    if (c.s.phase == PhName) begin
      if (!cn[4]) begin
        c  = set_fail(c);
        go = 1'b0;
      end else begin
        c.s.ptype = cn[3:0];
        c.s.cnt   = 3'd1;
        c.s.sfx   = SfxNone;
      end
    end else if (c.s.sfx == SfxColon) begin
      c  = set_fail(c);
      go = 1'b0;
    end
    if (go) begin
      if (c.s.cnt == 3'd3 && type_elem_bytes(c.s.ptype) < 3'd4) begin
        c = set_fail(c);
      end else begin
        c.s.pcomp = c.s.cnt;
        c.s.pinst = (c.s.sfx == SfxInst);
        c.s.phase = PhPeek;
        c.s.mpos  = '0;
      end
    end
    return c;
  endfunction

  function automatic ctx_t end_string(ctx_t c);
    unique case (c.s.phase)
      PhName, PhSuffix: begin
        c = finish_type(c);
        if (c.s.phase == PhPeek) begin
          c = commit(c, c.s.next_loc, 1'b0);
        end
      end
      PhPeek: begin
        if (c.s.mpos != '0) begin
          c = set_fail(c);
        end else begin
          c = commit(c, c.s.next_loc, 1'b0);
        end
      end
      PhDigits: begin
        if (c.s.mpos == '0) begin
          c = set_fail(c);
        end else begin
          c = commit(c, c.s.loc_acc, 1'b1);
        end
      end
      default: begin
      end
    endcase
    c.s.phase = PhHalt;
    return c;
  endfunction

  function automatic ctx_t process(ctx_t c, logic [7:0] ch);
    logic        sp;
    logic [10:0] acc;
    sp  = ch == ChSpace || (ch >= ChTab && ch <= ChCr);
    acc = '0;
    unique case (c.s.phase)
      PhGap: begin
        if (!sp) begin
          c = start_name(c, ch);
        end
      end
      PhName, PhSuffix: begin
        if (sp) begin
          c = finish_type(c);
        end else if (c.s.phase == PhName) begin
          c = name_feed(c, ch);
        end else begin
          c = suffix_feed(c, ch);
        end
      end
      PhPeek: begin
        if (!(c.s.mpos == '0 && sp)) begin
          if (c.s.mpos < 3'd4 && ch == attr_char(c.s.mpos[1:0])) begin
            c.s.mpos = c.s.mpos + 3'd1;
            if (c.s.mpos == 3'd4) begin
              c.s.phase   = PhDigits;
              c.s.mpos    = '0;
              c.s.loc_acc = '0;
            end
          end else if (c.s.mpos != '0) begin
            c = set_fail(c);
          end else begin
            c = commit(c, c.s.next_loc, 1'b0);
            if (!c.s.failed) begin
              c = start_name(c, ch);
            end
          end
        end
      end
      PhDigits: begin
        if (ch >= ChDigit0 && ch <= ChDigit9) begin
          acc = 11'(c.s.loc_acc) * 11'd10 + 11'(8'(ch - ChDigit0));
          c.s.loc_acc = (acc > 11'd127) ? 7'd127 : acc[6:0];
          c.s.mpos    = 3'd1;
        end else if (c.s.mpos == '0) begin
          c = set_fail(c);
        end else begin
          c = commit(c, c.s.loc_acc, 1'b1);
          if (!c.s.failed) begin
            if (sp) begin
              c.s.phase = PhGap;
            end else begin
              c = start_name(c, ch);
            end
          end
        end
      end
      default: begin
      end
    endcase
    return c;
  endfunction

  pst_t                     state_q, state_d;
  logic [MAX_LOCATIONS-1:0] used_q, used_d;

  always_comb begin
    ctx_t c;
    logic ok;
    c       = '{s: state_q, used: used_q, av: 1'b0, arec: '0};
    ok      = 1'b0;
    verdict_o       = '0;
    verdict_valid_o = 1'b0;
    if (c.s.phase != PhHalt) begin
      if (character_i == ChNul) begin
        c = end_string(c);
      end else begin
        c = process(c, character_i);
      end
    end
    state_d = c.s;
    used_d  = c.used;
    if (final_char_i) begin
      if (c.s.phase != PhHalt) begin
        c = end_string(c);
      end
      ok = !c.s.failed && c.s.total != '0;
      verdict_o = '{
        record_kind: RecKindVerdict, base_type: '0, components: '0, location: '0,
        byte_offset: '0, instanced: 1'b0, layout_ok: ok,
        stride: ok ? c.s.off : 10'd0, attribute_count: c.s.total
      };
      verdict_valid_o = 1'b1;
      state_d = PstReset;
      used_d  = '0;
    end
    attr_o       = c.arec;
    attr_valid_o = c.av;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= PstReset;
      used_q  <= '0;
    end else if (step_i) begin
      state_q <= state_d;
      used_q  <= used_d;
    end
  end

endmodule
`default_nettype wire

>>> src/vlsp_rec_fifo.sv
`default_nettype none
// ============================================================================
// vlsp_rec_fifo
// Small record queue taking up to two records per cycle and giving one.
// ============================================================================
module vlsp_rec_fifo import vlsp_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_a_i,
  input  wire rec_t data_a_i,
  input  wire logic push_b_i,
  input  wire rec_t data_b_i,
  output logic      room_o,
  output logic      valid_o,
  input  wire logic ready_i,
  output rec_t      data_o
);

  localparam int unsigned PtrW = $clog2(RecFifoDepth);
  localparam int unsigned CntW = $clog2(RecFifoDepth + 1);

  rec_t            mem_q [RecFifoDepth];
  logic [PtrW-1:0] wr_q, rd_q, wr_d, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            pop;

  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];
  assign room_o  = cnt_q <= CntW'(RecFifoDepth - 2);
  assign pop     = valid_o && ready_i;

  always_comb begin
    wr_d  = wr_q + PtrW'(push_a_i) + PtrW'(push_b_i);
    rd_d  = rd_q + PtrW'(pop);
    cnt_d = cnt_q + CntW'(push_a_i) + CntW'(push_b_i) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_a_i) begin
      mem_q[wr_q] <= data_a_i;
    end
    if (push_b_i) begin
      mem_q[wr_q + PtrW'(1)] <= data_b_i;
    end
  end

endmodule
`default_nettype wire

>>> src/vlsp_checker.sv
`default_nettype none
// ============================================================================
// vlsp_checker
// Port-level checks on the record channel of the layout string parser.
// ============================================================================
`include "vertex_layout_string_parser_assert.svh"

module vlsp_checker import vlsp_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       valid_i,
  input wire logic       ready_i,
  input wire logic       record_kind_i,
  input wire logic [3:0] base_type_i,
  input wire logic [2:0] components_i,
  input wire logic [4:0] location_i,
  input wire logic [8:0] byte_offset_i,
  input wire logic       instanced_i,
  input wire logic       layout_ok_i,
  input wire logic [9:0] stride_i,
  input wire logic [5:0] attribute_count_i
);

  `VLSP_ASSERT_NEXT(a_stall_hold, valid_i && !ready_i, valid_i && $stable(record_kind_i) && $stable(location_i) && $stable(byte_offset_i) && $stable(stride_i), "Stalled request changed.")
  `VLSP_ASSERT(a_verdict_clean, valid_i && record_kind_i == RecKindVerdict, base_type_i == '0 && components_i == '0 && location_i == '0 && byte_offset_i == '0 && !instanced_i, "Verdict carries attribute fields.")
  `VLSP_ASSERT(a_attr_clean, valid_i && record_kind_i == RecKindAttr, !layout_ok_i && stride_i == '0 && attribute_count_i == '0 && components_i != '0, "Attribute record is malformed.")
  `VLSP_ASSERT(a_verdict_stride, valid_i && record_kind_i == RecKindVerdict, (layout_ok_i && stride_i != '0 && attribute_count_i != '0) || (!layout_ok_i && stride_i == '0), "Verdict stride is inconsistent.")

endmodule

bind vertex_layout_string_parser vlsp_checker u_vlsp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .valid_i          (rec_o.valid),
  .ready_i          (rec_o.ready),
  .record_kind_i    (rec_o.record_kind),
  .base_type_i      (rec_o.base_type),
  .components_i     (rec_o.components),
  .location_i       (rec_o.location),
  .byte_offset_i    (rec_o.byte_offset),
  .instanced_i      (rec_o.instanced),
  .layout_ok_i      (rec_o.layout_ok),
  .stride_i         (rec_o.stride),
  .attribute_count_i(rec_o.attribute_count)
);
`default_nettype wire
